@@ src/wgi_pkg.sv @@
// Shared types and constants for the word graph isomorphism check unit.
// No dependencies; imported by every module of the block.
package wgi_pkg;

   localparam int MAX_LEN     = 7;
   localparam int LETTER_BITS = 3;
   localparam int WORD_W      = MAX_LEN * LETTER_BITS;
   localparam int VTX_W       = 3;
   localparam int CNT_W       = 5;
   localparam int LEN_W       = 3;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 8;

   // edge colour: earlier letter smaller, larger, or equal
   typedef enum logic [1:0] {
      COL_LT = 2'd0,
      COL_GT = 2'd1,
      COL_EQ = 2'd2
   } colour_type;

   typedef struct packed {
      colour_type colour_a;
      colour_type colour_b;
      logic       same;
   } edge_res_type;

endpackage

@@ src/wgi_edge_cmp.sv @@
// Shared edge colour evaluator and comparator for the isomorphism search.
// Depends on wgi_pkg.
module wgi_edge_cmp
   import wgi_pkg::*;
(
   input  logic [WORD_W-1:0] word_a,
   input  logic [WORD_W-1:0] word_b,
   input  logic [VTX_W-1:0]  xa,
   input  logic [VTX_W-1:0]  ya,
   input  logic [VTX_W-1:0]  xb,
   input  logic [VTX_W-1:0]  yb,
   output edge_res_type      res
);

   function automatic colour_type edge_colour(input logic [WORD_W-1:0] word,
                                              input logic [VTX_W-1:0]  x,
                                              input logic [VTX_W-1:0]  y);
      logic [VTX_W-1:0]       lo;
      logic [VTX_W-1:0]       hi;
      logic [WORD_W-1:0]      sh_lo;
      logic [WORD_W-1:0]      sh_hi;
      logic [LETTER_BITS-1:0] l_lo;
      logic [LETTER_BITS-1:0] l_hi;
      colour_type             c;
      lo    = (x < y) ? x : y;
      hi    = (x < y) ? y : x;
      sh_lo = word >> (LETTER_BITS * lo);
      sh_hi = word >> (LETTER_BITS * hi);
      l_lo  = sh_lo[LETTER_BITS-1:0];
      l_hi  = sh_hi[LETTER_BITS-1:0];
      if (l_lo < l_hi) begin
         c = COL_LT;
      end else if (l_lo > l_hi) begin
         c = COL_GT;
      end else begin
         c = COL_EQ;
      end
      return c;
   endfunction

   always_comb begin
      res.colour_a = edge_colour(word_a, xa, ya);
      res.colour_b = edge_colour(word_b, xb, yb);
      res.same     = (res.colour_a == res.colour_b);
   end

endmodule

@@ src/word_graph_isomorphism_check_unit.sv @@
// Top level of the word graph isomorphism check: sequencer, search state, output register.
// Depends on wgi_pkg and wgi_edge_cmp.
//
//   channel | dir | fields (tdata, low bit first)
//   req_    | in  | word_length[2:0], word_a[23:3], word_b[44:24], zero pad to 48
//   rsp_    | out | isomorphic[0], counts_match[1], zero pad to 8
//
// Per item: accept, a count pass over the C(len,2) edges, the search, then the load.
// Each search step is an edge compare, a used-vertex skip, a placement
// or a backtrack. Worst case is the full backtracking tree over 7 vertices.
// Reset (synchronous, active high) returns to idle and drops rsp_tvalid.
// req_tready is high only while idle; an item that finishes while the previous
// result still waits on rsp_tready holds its final load and the input stalls.
module word_graph_isomorphism_check_unit
   import wgi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // word_length, word_a, word_b
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // isomorphic, counts_match
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_SEARCH,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [WORD_W-1:0]      word_a_ff, word_a_in;
   logic [WORD_W-1:0]      word_b_ff, word_b_in;
   // count pass: pos is the later vertex j, k the earlier vertex i
   // search: pos is the B vertex being placed, v the A candidate, k the edge check
   logic [VTX_W-1:0]       pos_ff, pos_in;
   logic [VTX_W-1:0]       k_ff, k_in;
   logic [VTX_W-1:0]       v_ff, v_in;
   logic [MAX_LEN-1:0]     used_ff, used_in;
   logic [VTX_W-1:0]       map_ff [MAX_LEN];
   logic [VTX_W-1:0]       map_in [MAX_LEN];
   logic [CNT_W-1:0]       cnt_a_ff [3];
   logic [CNT_W-1:0]       cnt_a_in [3];
   logic [CNT_W-1:0]       cnt_b_ff [3];
   logic [CNT_W-1:0]       cnt_b_in [3];
   logic                   iso_ff, iso_in;
   logic                   match_ff, match_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                   backtrack;
   logic [VTX_W-1:0]       map_addr;
   logic [VTX_W-1:0]       map_rd;
   logic                   used_hit;
   logic                   counts_eq;
   logic [VTX_W-1:0]       xa;
   logic [VTX_W-1:0]       ya;
   edge_res_type           edge_res;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one read port on the mapping: backtrack needs the previous entry,
   // otherwise the edge check needs the entry under k
   assign backtrack = (state_ff == ST_SEARCH) && (pos_ff < len_ff) && (v_ff >= len_ff);
   assign map_addr  = backtrack ? VTX_W'(pos_ff - 1'b1) : k_ff;
   assign map_rd    = map_ff[map_addr];
   assign used_hit  = (v_ff < len_ff) && used_ff[v_ff];
   assign counts_eq = (cnt_a_ff[COL_LT] == cnt_b_ff[COL_LT]) &&
                      (cnt_a_ff[COL_GT] == cnt_b_ff[COL_GT]) &&
                      (cnt_a_ff[COL_EQ] == cnt_b_ff[COL_EQ]);

   // count pass looks at edge (k,pos) in both graphs; search looks at
   // A edge (map[k], v) against B edge (k, pos)
   assign xa = (state_ff == ST_COUNT) ? k_ff : map_rd;
   assign ya = (state_ff == ST_COUNT) ? pos_ff : v_ff;

   wgi_edge_cmp u_edge_cmp (
      .word_a (word_a_ff),
      .word_b (word_b_ff),
      .xa     (xa),
      .ya     (ya),
      .xb     (k_ff),
      .yb     (pos_ff),
      .res    (edge_res)
   );

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      word_a_in    = word_a_ff;
      word_b_in    = word_b_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      v_in         = v_ff;
      used_in      = used_ff;
      map_in       = map_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      iso_in       = iso_ff;
      match_in     = match_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               len_in    = req_tdata[LEN_W-1:0];
               word_a_in = req_tdata[LEN_W +: WORD_W];
               word_b_in = req_tdata[LEN_W+WORD_W +: WORD_W];
               pos_in    = VTX_W'(1);
               k_in      = '0;
               cnt_a_in  = '{default: '0};
               cnt_b_in  = '{default: '0};
               state_in  = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (pos_ff >= len_ff) begin
               match_in = counts_eq;
               iso_in   = 1'b0;
               pos_in   = '0;
               k_in     = '0;
               v_in     = '0;
               used_in  = '0;
               state_in = counts_eq ? ST_SEARCH : ST_DONE;
            end else begin
               cnt_a_in[edge_res.colour_a] = CNT_W'(cnt_a_ff[edge_res.colour_a] + 1'b1);
               cnt_b_in[edge_res.colour_b] = CNT_W'(cnt_b_ff[edge_res.colour_b] + 1'b1);
               if (VTX_W'(k_ff + 1'b1) == pos_ff) begin
                  pos_in = VTX_W'(pos_ff + 1'b1);
                  k_in   = '0;
               end else begin
                  k_in = VTX_W'(k_ff + 1'b1);
               end
            end
         end
         ST_SEARCH: begin
            if (pos_ff >= len_ff) begin
               // every B vertex placed
               iso_in   = 1'b1;
               state_in = ST_DONE;
            end else if (backtrack) begin
               if (pos_ff == '0) begin
                  iso_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  pos_in          = VTX_W'(pos_ff - 1'b1);
                  v_in            = VTX_W'(map_rd + 1'b1);
                  used_in[map_rd] = 1'b0;
                  k_in            = '0;
               end
            end else if (used_hit) begin
               v_in = VTX_W'(v_ff + 1'b1);
               k_in = '0;
            end else if (k_ff < pos_ff) begin
               if (edge_res.same) begin
                  k_in = VTX_W'(k_ff + 1'b1);
               end else begin
                  v_in = VTX_W'(v_ff + 1'b1);
                  k_in = '0;
               end
            end else begin
               // all edges to placed vertices agree: place and descend
               map_in[pos_ff] = v_ff;
               used_in[v_ff]  = 1'b1;
               pos_in         = VTX_W'(pos_ff + 1'b1);
               v_in           = '0;
               k_in           = '0;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W-2){1'b0}}, match_ff, iso_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff      <= len_in;
      word_a_ff   <= word_a_in;
      word_b_ff   <= word_b_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      v_ff        <= v_in;
      used_ff     <= used_in;
      map_ff      <= map_in;
      cnt_a_ff    <= cnt_a_in;
      cnt_b_ff    <= cnt_b_in;
      iso_ff      <= iso_in;
      match_ff    <= match_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ src/wgi_checker.sv @@
// Port-level checker for word_graph_isomorphism_check_unit, with its bind.
// Depends on wgi_pkg and the top level's ports.
module wgi_checker
   import wgi_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // an isomorphic pair always has matching colour counts
   a_iso_implies_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[0] || rsp_tdata[1]))
      else $error("isomorphic without matching counts");

   // one item at a time: busy right after an input transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accepting an item");

   // a new result is loaded only while the block is busy
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without work in progress");

endmodule

bind word_graph_isomorphism_check_unit wgi_checker u_wgi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
